/* design/rswg_pkg.sv */
package rswg_pkg;

  localparam int MAX_GRID_DEF = 1024;

  localparam int COORD_W  = 10;
  localparam int GRID_W   = 11;
  localparam int KIND_W   = 2;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int DR_W     = FRAC_W + 1;

  localparam logic [DR_W-1:0] ONE_Q16 = DR_W'(1) << FRAC_W;

  // register indexes
  localparam logic [0:0] CFG_STAMP_KIND = 1'b0;
  localparam logic [0:0] CFG_GRID_SIZE  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_MOUNTAIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALLEY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CRATER   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_RESET = KIND_MOUNTAIN;
  localparam logic [GRID_W-1:0] GRID_RESET = 11'd64;

  // travels with each item down the pipe
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              outside;
    logic              s_zero;
  } item_ctl_t;

endpackage

/* design/rswg_front.sv */
module rswg_front
  import rswg_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF,
  parameter int RW       = $clog2(MAX_GRID)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [COORD_W-1:0]  col_i,
  input  logic [COORD_W-1:0]  row_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [GRID_W-1:0]   grid_size_i,
  output logic                valid_o,
  output logic [2*RW-1:0]     s_o,
  output logic [RW-1:0]       r_o,
  output item_ctl_t           ctl_o
);

  localparam int CW = (GRID_W > RW + 1) ? GRID_W : RW + 1;
  localparam int MW = (COORD_W + 1 > RW) ? COORD_W + 1 : RW;
  localparam int DW = MW + 1;
  localparam int SW = 2 * MW + 1;

  logic [CW-1:0]        gs_w, n_w;
  logic [RW-1:0]        r_d;
  logic signed [DW-1:0] dx, dz;

  logic                 v1_q, v2_q, v3_q;
  logic [MW-1:0]        ax_q, az_q;
  logic [RW-1:0]        r1_q, r2_q, r3_q;
  logic [KIND_W-1:0]    k1_q, k2_q;
  logic [2*MW-1:0]      sqx_q, sqz_q;
  logic [2*RW-1:0]      rsq_q;
  logic [SW-1:0]        s_sum;
  logic                 outside_d;
  logic [2*RW-1:0]      s_q;
  item_ctl_t            ctl_q;

  always_comb begin
    gs_w = CW'(grid_size_i);
    if (gs_w == '0) begin
      n_w = CW'(1);
    end else if (gs_w > CW'(MAX_GRID)) begin
      n_w = CW'(MAX_GRID);
    end else begin
      n_w = gs_w;
    end
    r_d = RW'(n_w - CW'(1));
    dx  = $signed(DW'({col_i, 1'b0})) - $signed(DW'(r_d));
    dz  = $signed(DW'({row_i, 1'b0})) - $signed(DW'(r_d));
  end

  assign s_sum     = SW'(sqx_q) + SW'(sqz_q);
  assign outside_d = s_sum > SW'(rsq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= dx[DW-1] ? MW'(-dx) : MW'(dx);
    az_q  <= dz[DW-1] ? MW'(-dz) : MW'(dz);
    r1_q  <= r_d;
    k1_q  <= kind_i;

    sqx_q <= ax_q * ax_q;
    sqz_q <= az_q * az_q;
    rsq_q <= r1_q * r1_q;
    r2_q  <= r1_q;
    k2_q  <= k1_q;

    // only the inside range feeds the root unit
    s_q           <= outside_d ? '0 : (2*RW)'(s_sum);
    ctl_q.outside <= outside_d;
    ctl_q.s_zero  <= (s_sum == '0);
    ctl_q.kind    <= k2_q;
    r3_q          <= r2_q;
  end

  assign valid_o = v3_q;
  assign s_o     = s_q;
  assign r_o     = r3_q;
  assign ctl_o   = ctl_q;

endmodule

/* design/rswg_sqrt.sv */
module rswg_sqrt
  import rswg_pkg::*;
#(
  parameter int RW = $clog2(MAX_GRID_DEF),
  parameter int K  = RW + FRAC_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] s_i,
  input  logic [RW-1:0]   r_i,
  input  item_ctl_t       ctl_i,
  output logic            valid_o,
  output logic [K-1:0]    root_o,
  output logic [RW-1:0]   r_o,
  output item_ctl_t       ctl_o
);

  // isqrt(s << 32), two radicand bits per stage
  logic [2*K-1:0] x_q    [0:K];
  logic [K+1:0]   rem_q  [0:K];
  logic [K-1:0]   root_q [0:K];
  logic [RW-1:0]  r_q    [0:K];
  item_ctl_t      ctl_q  [0:K];
  logic [K:0]     vld_q;

  assign x_q[0]    = {s_i, {(2*FRAC_W){1'b0}}};
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign r_q[0]    = r_i;
  assign ctl_q[0]  = ctl_i;
  assign vld_q[0]  = valid_i;

  for (genvar i = 0; i < K; i++) begin : g_step
    logic [K+1:0] rem_sh, trial;
    logic         ge;

    assign rem_sh = {rem_q[i][K-1:0], x_q[i][2*K-1:2*K-2]};
    assign trial  = {root_q[i], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_q[i] << 2;
      rem_q[i+1]  <= ge ? rem_sh - trial : rem_sh;
      root_q[i+1] <= {root_q[i][K-2:0], ge};
      r_q[i+1]    <= r_q[i];
      ctl_q[i+1]  <= ctl_q[i];
    end
  end

  assign valid_o = vld_q[K];
  assign root_o  = root_q[K];
  assign r_o     = r_q[K];
  assign ctl_o   = ctl_q[K];

endmodule

/* design/rswg_div.sv */
module rswg_div
  import rswg_pkg::*;
#(
  parameter int RW = $clog2(MAX_GRID_DEF),
  parameter int K  = RW + FRAC_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [K-1:0]     q_i,
  input  logic [RW-1:0]    r_i,
  input  item_ctl_t        ctl_i,
  output logic             valid_o,
  output logic [DR_W-1:0]  dr_o,
  output item_ctl_t        ctl_o
);

  // q < r * 2^17, so the bits above the quotient already sit below r
  logic [K-1:0]    q_q   [0:DR_W];
  logic [RW-1:0]   rem_q [0:DR_W];
  logic [DR_W-1:0] quo_q [0:DR_W];
  logic [RW-1:0]   r_q   [0:DR_W];
  item_ctl_t       ctl_q [0:DR_W];
  logic [DR_W:0]   vld_q;

  assign q_q[0]   = q_i;
  assign rem_q[0] = RW'(q_i >> DR_W);
  assign quo_q[0] = '0;
  assign r_q[0]   = r_i;
  assign ctl_q[0] = ctl_i;
  assign vld_q[0] = valid_i;

  for (genvar i = 0; i < DR_W; i++) begin : g_step
    logic [RW:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_q[i], q_q[i][DR_W-1-i]};
    assign ge     = rem_sh >= {1'b0, r_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      q_q[i+1]   <= q_q[i];
      rem_q[i+1] <= ge ? RW'(rem_sh - {1'b0, r_q[i]}) : RW'(rem_sh);
      quo_q[i+1] <= {quo_q[i][DR_W-2:0], ge};
      r_q[i+1]   <= r_q[i];
      ctl_q[i+1] <= ctl_q[i];
    end
  end

  assign valid_o = vld_q[DR_W];
  assign dr_o    = quo_q[DR_W];
  assign ctl_o   = ctl_q[DR_W];

endmodule

/* design/rswg_shape.sv */
module rswg_shape
  import rswg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [DR_W-1:0]            dr_i,
  input  item_ctl_t                  ctl_i,
  output logic                       valid_o,
  output logic signed [WEIGHT_W-1:0] weight_o,
  output logic                       outside_o
);

  localparam int TW = DR_W + 3;
  localparam int UW = 2 * DR_W;
  localparam int FW = DR_W + 1;
  localparam int PW = UW + FW;
  localparam int HW = 15;
  localparam logic [FW-1:0] THREE_Q16 = FW'(3) << FRAC_W;
  localparam logic [PW-1:0] HALF_Q34  = PW'(1) << (2 * FRAC_W + 1);

  function automatic logic [DR_W-1:0] clamp_t(input logic signed [TW-1:0] v);
    logic [DR_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(TW'(ONE_Q16))) begin
      res = ONE_Q16;
    end else begin
      res = v[DR_W-1:0];
    end
    return res;
  endfunction

  logic [DR_W-1:0]        dr_e;
  logic [DR_W+1:0]        dr5;
  logic signed [TW-1:0]   t1, t2;
  logic [DR_W-1:0]        ta_d, tb_d;

  logic [3:0]             vld_q;
  item_ctl_t              c1_q, c2_q, c3_q;
  logic [DR_W-1:0]        ta_q, tb_q;
  logic [UW-1:0]          uua_q, uub_q;
  logic [FW-1:0]          fa_q, fb_q;
  logic [PW-1:0]          pa_q, pb_q;
  logic [PW-1:0]          ra, rb;
  logic signed [HW+1:0]   ha, hb, w_d;
  logic signed [WEIGHT_W-1:0] weight_q;
  logic                   outside_q;

  always_comb begin
    dr_e = ctl_i.s_zero ? '0 : dr_i;
    dr5  = {dr_e, 2'b00} + (DR_W+2)'(dr_e);
    t1   = $signed(TW'(dr5)) - $signed(TW'(3) << FRAC_W);
    t2   = $signed(TW'(dr5)) - $signed(TW'(4) << FRAC_W);
    if (ctl_i.kind == KIND_CRATER) begin
      ta_d = clamp_t(t1);
      tb_d = clamp_t(t2);
    end else begin
      ta_d = ONE_Q16 - dr_e;
      tb_d = '0;
    end
  end

  always_comb begin
    ra = (pa_q + HALF_Q34) >> (2 * FRAC_W + 2);
    rb = (pb_q + HALF_Q34) >> (2 * FRAC_W + 2);
    ha = $signed({2'b00, ra[HW-1:0]});
    hb = $signed({2'b00, rb[HW-1:0]});
    case (c3_q.kind)
      KIND_MOUNTAIN: w_d = ha;
      KIND_VALLEY:   w_d = -ha;
      KIND_CRATER:   w_d = hb - ha;
      default:       w_d = '0;
    endcase
    if (c3_q.outside) begin
      w_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q      <= ta_d;
    tb_q      <= tb_d;
    c1_q      <= ctl_i;

    uua_q     <= ta_q * ta_q;
    uub_q     <= tb_q * tb_q;
    fa_q      <= THREE_Q16 - {ta_q, 1'b0};
    fb_q      <= THREE_Q16 - {tb_q, 1'b0};
    c2_q      <= c1_q;

    pa_q      <= uua_q * fa_q;
    pb_q      <= uub_q * fb_q;
    c3_q      <= c2_q;

    weight_q  <= WEIGHT_W'(w_d);
    outside_q <= c3_q.outside;
  end

  assign valid_o   = vld_q[3];
  assign weight_o  = weight_q;
  assign outside_o = outside_q;

endmodule

/* design/radial_stamp_weight_generator.sv */
// Radial smoothstep weight, one cell item per clock.
// Items run from start to done through the front end, the one-bit-per-stage square root and
// divider pipelines, and the shape pipeline.
// Throughput: one item per cycle; busy_o stays low and the receiver cannot stall.
// Reset clears the valid bits and loads stamp_kind 0, grid_size 64.
module radial_stamp_weight_generator
  import rswg_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [COORD_W-1:0]         cell_col_i,
  input  logic [COORD_W-1:0]         cell_row_i,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [GRID_W-1:0]          cfg_data_i,
  output logic                       done_o,
  output logic signed [WEIGHT_W-1:0] weight_o,
  output logic                       outside_disc_o
);

  localparam int RW      = $clog2(MAX_GRID);
  localparam int K       = RW + FRAC_W;

  logic [KIND_W-1:0] stamp_kind_q;
  logic [GRID_W-1:0] grid_size_q;

  logic              f_vld, s_vld, d_vld;
  logic [2*RW-1:0]   f_s;
  logic [RW-1:0]     f_r, s_r;
  logic [K-1:0]      s_root;
  logic [DR_W-1:0]   d_dr;
  item_ctl_t         f_ctl, s_ctl, d_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_kind_q <= KIND_RESET;
      grid_size_q  <= GRID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STAMP_KIND: stamp_kind_q <= cfg_data_i[KIND_W-1:0];
        CFG_GRID_SIZE:  grid_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  rswg_front #(.MAX_GRID(MAX_GRID), .RW(RW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start_i),
    .col_i       (cell_col_i),
    .row_i       (cell_row_i),
    .kind_i      (stamp_kind_q),
    .grid_size_i (grid_size_q),
    .valid_o     (f_vld),
    .s_o         (f_s),
    .r_o         (f_r),
    .ctl_o       (f_ctl)
  );

  rswg_sqrt #(.RW(RW), .K(K)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld),
    .s_i     (f_s),
    .r_i     (f_r),
    .ctl_i   (f_ctl),
    .valid_o (s_vld),
    .root_o  (s_root),
    .r_o     (s_r),
    .ctl_o   (s_ctl)
  );

  rswg_div #(.RW(RW), .K(K)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_vld),
    .q_i     (s_root),
    .r_i     (s_r),
    .ctl_i   (s_ctl),
    .valid_o (d_vld),
    .dr_o    (d_dr),
    .ctl_o   (d_ctl)
  );

  rswg_shape u_shape (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (d_vld),
    .dr_i      (d_dr),
    .ctl_i     (d_ctl),
    .valid_o   (done_o),
    .weight_o  (weight_o),
    .outside_o (outside_disc_o)
  );

endmodule

/* design/rswg_checker.sv */
module rswg_checker
  import rswg_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic signed [WEIGHT_W-1:0] weight_o,
  input logic                       outside_disc_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("busy raised while pipeline accepts every cycle");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && outside_disc_o |-> weight_o == '0)
    else $error("nonzero weight outside the disc");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (weight_o >= -16'sd16384) && (weight_o <= 16'sd16384))
    else $error("weight beyond plus or minus one");

endmodule

bind radial_stamp_weight_generator rswg_checker u_rswg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .weight_o       (weight_o),
  .outside_disc_o (outside_disc_o)
);
